[design/tli_pkg.sv]
// Shared constants, types and table-building functions for the trig lookup interpolator.
// Depends on nothing; every other design file but tli_if imports it.
package tli_pkg;

  // Default number of entries in each quarter-wave table.
  localparam int ROM_DEPTH_DEF = 256;

  // Operation codes carried on the op field. The fourth code selects nothing.
  typedef enum logic [1:0] {
    OP_SIN = 2'b00,
    OP_COS = 2'b01,
    OP_TAN = 2'b10
  } op_t;

  // Angles inside the block are Q32 radians (input angle times 4096).
  localparam longint PI_Q32      = 64'sh3243F6A89;
  localparam longint HALF_PI_Q32 = 64'sh1921FB544;
  localparam longint TWO_PI_Q32  = 64'sh6487ED511;
  localparam longint ONE_Q30     = 64'sh40000000;
  localparam longint TAN_SAT     = 64'sh1FFFFFFFC000;

  localparam int RAW_W   = 38;  // angle after the cosine offset
  localparam int RED_W   = 35;  // angle after whole-turn reduction
  localparam int MAG_W   = 33;  // folded magnitude, at most pi/2 plus one
  localparam int RECIP_SHIFT = 49;
  localparam int RECIP_W = 29;  // reciprocal constant for the index divide
  localparam int REM_W   = 35;  // remainder window for the divide correction
  localparam int FRAC_W  = 16;
  localparam int ENT_W   = 45;  // table entry, Q30, tangent saturates near 2^45
  localparam int VAL_W   = 32;

  typedef struct packed {
    logic neg;
    logic tan;
    logic zero;
  } flags_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    flags_t           fl;
  } fold_t;

  typedef struct packed {
    flags_t fl;
    logic   last;
  } lookup_ctl_t;

  // Restoring division, used only while the tables are built at elaboration.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Signed division that truncates toward zero.
  function automatic longint sdiv64(input longint num, input longint den);
    longint unsigned nm;
    longint unsigned dm;
    longint unsigned qm;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    qm = udiv64(nm, dm);
    return ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
  endfunction

  // Angle of table entry k, Q30.
  function automatic longint grid_q30(input int k, input int n);
    return longint'(udiv64(longint'(k) * HALF_PI_Q32, longint'(n - 1) * 4));
  endfunction

  // Truncating eleven-term Taylor series in Q30: sine when odd is set, else cosine.
  function automatic longint series_q30(input longint x, input bit odd);
    longint x2;
    longint term;
    longint sum;
    longint d;
    x2   = (x * x) >>> 30;
    term = odd ? x : ONE_Q30;
    sum  = term;
    for (int n = 1; n <= 10; n++) begin
      d    = odd ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
      term = -sdiv64(term * x2, d * ONE_Q30);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic longint rom_sin(input int k, input int n);
    longint s;
    s = series_q30(grid_q30(k, n), 1'b1);
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    return s;
  endfunction

  function automatic longint rom_tan(input int k, input int n);
    longint x;
    longint s;
    longint c;
    longint t;
    if (k >= n - 1) return TAN_SAT;
    x = grid_q30(k, n);
    s = series_q30(x, 1'b1);
    c = series_q30(x, 1'b0);
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    if (c <= 0) return TAN_SAT;
    t = longint'(udiv64(s * ONE_Q30, c));
    if (t > TAN_SAT) t = TAN_SAT;
    return t;
  endfunction

endpackage

[design/tli_if.sv]
// Handshake channels of the trig lookup interpolator: the request and result interfaces.
// Standalone; no package needed.
interface tli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [23:0] angle;

  modport source (output valid, op, angle, input ready);
  modport sink   (input valid, op, angle, output ready);
endinterface

interface tli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

[design/tli_reduce.sv]
// Front pipeline: cosine offset, reduction by whole turns, quadrant folding.
// Depends on tli_pkg.
module tli_reduce
  import tli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [1:0]         op,
  input  logic signed [23:0] angle,
  output logic               dn_valid,
  input  logic               dn_ready,
  output fold_t              fold
);

  localparam logic signed [RAW_W-1:0] PI_R   = PI_Q32[RAW_W-1:0];
  localparam logic signed [RAW_W-1:0] HALF_R = HALF_PI_Q32[RAW_W-1:0];
  localparam logic signed [RAW_W-1:0] TURN_R = TWO_PI_Q32[RAW_W-1:0];
  localparam logic signed [RAW_W-1:0] S_STEP1 = TURN_R;
  localparam logic signed [RAW_W-1:0] S_STEP2 = 2 * TURN_R;
  localparam logic signed [RAW_W-1:0] S_STEP3 = 3 * TURN_R;
  localparam logic signed [RAW_W-1:0] T_STEP1 = PI_R;
  localparam logic signed [RAW_W-1:0] T_STEP2 = 2 * PI_R;
  localparam logic signed [RAW_W-1:0] T_STEP3 = 3 * PI_R;
  localparam logic signed [RED_W-1:0] PI_N   = PI_Q32[RED_W-1:0];
  localparam logic signed [RED_W-1:0] HALF_N = HALF_PI_Q32[RED_W-1:0];
  localparam logic [MAG_W-1:0]        MAG_MAX = MAG_W'(HALF_PI_Q32 + 1);

  logic en1, en2, en3;
  logic v1, v2, v3;
  logic signed [RAW_W-1:0] r0;
  logic [1:0]              op1;
  logic signed [RED_W-1:0] red;
  logic [1:0]              op2;
  fold_t                   fold_q;

  logic signed [RAW_W-1:0] q32;
  logic signed [RAW_W-1:0] r0_next;
  logic                    tan1;
  logic signed [RAW_W-1:0] hi, lo, st1, st2, st3;
  logic signed [RAW_W-1:0] dn1, dn2, dn3, upw1, upw2, upw3;
  logic signed [RAW_W-1:0] red_sel;
  logic signed [RED_W-1:0] mag_s;
  fold_t                   fold_next;

  assign en3      = !v3 || dn_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;
  assign dn_valid = v3;
  assign fold     = fold_q;

  // Stage 1: Q3.20 to Q32, cosine becomes sine of the complement.
  assign q32     = $signed({{2{angle[23]}}, angle, 12'b0});
  assign r0_next = (op == OP_COS) ? HALF_R - q32 : q32;

  // Stage 2: all turn counts are tried at once, the smallest that lands wins.
  assign tan1 = (op1 == OP_TAN);
  assign hi   = tan1 ? HALF_R : PI_R;
  assign lo   = -hi;
  assign st1  = tan1 ? T_STEP1 : S_STEP1;
  assign st2  = tan1 ? T_STEP2 : S_STEP2;
  assign st3  = tan1 ? T_STEP3 : S_STEP3;
  assign dn1  = r0 - st1;
  assign dn2  = r0 - st2;
  assign dn3  = r0 - st3;
  assign upw1 = r0 + st1;
  assign upw2 = r0 + st2;
  assign upw3 = r0 + st3;

  always_comb begin
    red_sel = r0;
    if (r0 > hi) begin
      if (dn1 <= hi)      red_sel = dn1;
      else if (dn2 <= hi) red_sel = dn2;
      else                red_sel = dn3;
    end else if (r0 < lo) begin
      if (upw1 >= lo)      red_sel = upw1;
      else if (upw2 >= lo) red_sel = upw2;
      else                 red_sel = upw3;
    end
  end

  // Stage 3: fold into the first quadrant and note the sign.
  always_comb begin
    fold_next = '0;
    mag_s     = '0;
    case (op2)
      OP_SIN, OP_COS: begin
        fold_next.fl.neg = red[RED_W-1];
        if (red[RED_W-1]) begin
          mag_s = (red < -HALF_N) ? PI_N + red : -red;
        end else begin
          mag_s = (red < HALF_N) ? red : PI_N - red;
        end
      end
      OP_TAN: begin
        fold_next.fl.tan = 1'b1;
        fold_next.fl.neg = !(red > 0);
        mag_s = (red > 0) ? red : -red;
      end
      default: begin
        fold_next.fl.zero = 1'b1;
      end
    endcase
    fold_next.mag = mag_s[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      r0  <= r0_next;
      op1 <= op;
    end
    if (en2 && v1) begin
      red <= red_sel[RED_W-1:0];
      op2 <= op1;
    end
    if (en3 && v2) begin
      fold_q <= fold_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_tan_range: assert property (@(posedge clk) disable iff (rst)
    v2 && (op2 == OP_TAN) |-> (red >= -HALF_N) && (red <= HALF_N))
    else $error("tangent angle left the half-turn window after reduction");

  a_sin_range: assert property (@(posedge clk) disable iff (rst)
    v2 && (op2 != OP_TAN) |-> (red >= -PI_N) && (red <= PI_N))
    else $error("sine angle left the whole-turn window after reduction");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> fold_q.mag <= MAG_MAX)
    else $error("folded magnitude exceeds a quarter turn");
`endif

endmodule

[design/tli_index.sv]
// Index pipeline: splits the folded magnitude into table index and fraction.
// A reciprocal multiply gives the quotient to within one, a remainder check fixes it.
// Depends on tli_pkg.
module tli_index
  import tli_pkg::*;
#(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
)(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  fold_t                          fold,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [$clog2(ROM_DEPTH)-1:0]   idx,
  output logic [FRAC_W-1:0]              frac,
  output lookup_ctl_t                    ctl
);

  localparam int IW = $clog2(ROM_DEPTH);
  localparam int QW = IW + FRAC_W;
  localparam int PW = MAG_W + RECIP_W;
  localparam int QLO = RECIP_SHIFT - FRAC_W;
  localparam int XL_W = REM_W - FRAC_W;
  localparam longint unsigned RECIP_FULL =
    (longint'(ROM_DEPTH - 1) << RECIP_SHIFT) / HALF_PI_Q32;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
  localparam logic [REM_W-1:0]   HALF_M  = HALF_PI_Q32[REM_W-1:0];
  localparam logic [REM_W-1:0]   REM_MAX = REM_W'(2 * HALF_PI_Q32);
  localparam logic [IW-1:0]      LAST_IDX = IW'(ROM_DEPTH - 1);

  logic en4, en5, en6;
  logic v4, v5, v6;
  logic [QW-1:0]    qe4, qe5;
  logic [XL_W-1:0]  xl;
  logic [REM_W-1:0] rem;
  flags_t           fl4, fl5;
  logic [IW-1:0]    idx_q;
  logic [FRAC_W-1:0] frac_q;
  lookup_ctl_t      ctl_q;

  logic [PW-1:0]    prod;
  logic [XL_W-1:0]  xl_next;
  logic [REM_W-1:0] qh;
  logic [REM_W-1:0] rem_next;
  logic [QW-1:0]    q;

  assign en6      = !v6 || dn_ready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign up_ready = en4;
  assign dn_valid = v6;
  assign idx      = idx_q;
  assign frac     = frac_q;
  assign ctl      = ctl_q;

  // Stage 4: quotient estimate, and the low bits of magnitude times (size - 1).
  assign prod    = PW'(fold.mag) * PW'(RECIP);
  assign xl_next = XL_W'(fold.mag[XL_W-1:0]) * XL_W'(ROM_DEPTH - 1);

  // Stage 5: remainder; its true value is below two quarter turns.
  assign qh       = REM_W'(qe4) * HALF_M;
  assign rem_next = {xl, {FRAC_W{1'b0}}} - qh;

  // Stage 6: the estimate is low by at most one.
  assign q = qe5 + QW'(rem >= HALF_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= up_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && up_valid) begin
      qe4 <= prod[QLO+QW-1:QLO];
      xl  <= xl_next;
      fl4 <= fold.fl;
    end
    if (en5 && v4) begin
      rem <= rem_next;
      qe5 <= qe4;
      fl5 <= fl4;
    end
    if (en6 && v5) begin
      idx_q     <= q[QW-1:FRAC_W];
      frac_q    <= q[FRAC_W-1:0];
      ctl_q.fl  <= fl5;
      ctl_q.last <= (q[QW-1:FRAC_W] >= LAST_IDX);
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_window: assert property (@(posedge clk) disable iff (rst)
    v5 |-> rem < REM_MAX)
    else $error("reciprocal estimate off by more than one");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    v6 |-> idx_q <= LAST_IDX)
    else $error("table index beyond the last entry");
`endif

endmodule

[design/tli_interp.sv]
// Interpolation pipeline: table read, linear blend, rounding, saturation and sign.
// The sine and tangent tables are constants built from tli_pkg functions at elaboration.
module tli_interp
  import tli_pkg::*;
#(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
)(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [$clog2(ROM_DEPTH)-1:0]  idx,
  input  logic [FRAC_W-1:0]             frac,
  input  lookup_ctl_t                   ctl,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [VAL_W-1:0]       value
);

  localparam int IW = $clog2(ROM_DEPTH);
  localparam int DW = ENT_W + 1;
  localparam int PMW = DW + FRAC_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ROM_DEPTH - 1);
  localparam logic [VAL_W-2:0] MAG_SAT = '1;

  logic [ENT_W-1:0] sin_rom [ROM_DEPTH];
  logic [ENT_W-1:0] tan_rom [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam longint SIN_K = rom_sin(k, ROM_DEPTH);
    localparam longint TAN_K = rom_tan(k, ROM_DEPTH);
    assign sin_rom[k] = SIN_K[ENT_W-1:0];
    assign tan_rom[k] = TAN_K[ENT_W-1:0];
  end

  logic en7, en8, en9;
  logic v7, v8, v9;
  logic [ENT_W-1:0]        e0;
  logic signed [DW-1:0]    dlt;
  logic [FRAC_W-1:0]       frac7;
  flags_t                  fl7, fl8;
  logic signed [63:0]      m;
  logic signed [VAL_W-1:0] value_q;

  logic [IW-1:0]           addr0, addr1;
  logic [ENT_W-1:0]        rd0, rd1;
  logic signed [PMW-1:0]   pm;
  logic signed [63:0]      m_next;
  logic [62:0]             mc;
  logic [63:0]             rnd;
  logic [VAL_W-2:0]        mag;
  logic signed [VAL_W-1:0] value_next;

  assign en9      = !v9 || dn_ready;
  assign en8      = !v8 || en9;
  assign en7      = !v7 || en8;
  assign up_ready = en7;
  assign dn_valid = v9;
  assign value    = value_q;

  // Stage 7: read both neighbors; the last entry stands alone.
  assign addr0 = ctl.last ? LAST_IDX : idx;
  assign addr1 = ctl.last ? LAST_IDX : idx + IW'(1);
  assign rd0   = ctl.fl.tan ? tan_rom[addr0] : sin_rom[addr0];
  assign rd1   = ctl.fl.tan ? tan_rom[addr1] : sin_rom[addr1];

  // Stage 8: magnitude in Q46.
  assign pm     = PMW'(dlt) * PMW'($signed({1'b0, frac7}));
  assign m_next = $signed({3'b0, e0, {FRAC_W{1'b0}}}) + 64'(pm);

  // Stage 9: round half up to Q16, saturate, apply sign.
  assign mc  = m[63] ? '0 : m[62:0];
  assign rnd = {1'b0, mc} + 64'(64'd1 << 29);
  assign mag = (rnd[63:30] > 34'(MAG_SAT)) ? MAG_SAT : rnd[60:30];

  always_comb begin
    if (fl8.zero) begin
      value_next = '0;
    end else if (fl8.neg) begin
      value_next = -$signed({1'b0, mag});
    end else begin
      value_next = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (en7) v7 <= up_valid;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en7 && up_valid) begin
      e0    <= rd0;
      dlt   <= ctl.last ? '0 : $signed({1'b0, rd1}) - $signed({1'b0, rd0});
      frac7 <= ctl.last ? '0 : frac;
      fl7   <= ctl.fl;
    end
    if (en8 && v7) begin
      m   <= m_next;
      fl8 <= fl7;
    end
    if (en9 && v8) begin
      value_q <= value_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_sign: assert property (@(posedge clk) disable iff (rst)
    v8 && en9 && !fl8.neg |=> !value_q[VAL_W-1])
    else $error("positive result came out negative");
`endif

endmodule

[design/trig_lookup_interpolator_top.sv]
// Top level of the trig lookup interpolator: sine, cosine and tangent by table lookup.
// Depends on tli_pkg, tli_if, tli_reduce, tli_index and tli_interp.
//
// The block takes an item of op (0 sine, 1 cosine, 2 tangent, 3 gives zero) and a signed
// Q3.20 angle in radians, and returns one item with a signed Q16.16 value. It is a nine
// stage pipeline that accepts one item in every clock cycle while the result side is not
// stalled. Three stages reduce the angle by whole turns (half turns for tangent) and fold
// it into the first quadrant, three split the folded angle into a table index and a 16 bit
// fraction through a reciprocal multiply with a one-step correction, and three read the
// quarter-wave table, blend the two neighboring entries and round, saturate and sign the
// result. The index divide's 33 by 29 bit multiply and remainder check take a stage each.
// Every stage carries its own valid bit and holds its contents while the next stage is
// full, so a stall on the result side neither drops nor repeats an item, and empty stages
// still take new items while a finished result waits. The sine and tangent tables hold
// ROM_DEPTH entries each and are constants fixed at elaboration, so there is no start-up
// fill and the block is ready right after reset. Tangent saturates to plus or minus
// 0x7FFFFFFF at the quarter-turn points.
module trig_lookup_interpolator_top
  import tli_pkg::*;
#(
  parameter int ROM_DEPTH = ROM_DEPTH_DEF
)(
  input logic        clk,
  input logic        rst,
  tli_in_if.sink     sample,
  tli_out_if.source  result
);

  localparam int IW = $clog2(ROM_DEPTH);

  // Folded angle between the reduction and index pipelines.
  logic  fold_valid;
  logic  fold_ready;
  fold_t fold;

  // Table coordinates between the index and interpolation pipelines.
  logic              pt_valid;
  logic              pt_ready;
  logic [IW-1:0]     pt_idx;
  logic [FRAC_W-1:0] pt_frac;
  lookup_ctl_t       pt_ctl;

  tli_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sample.valid),
    .up_ready (sample.ready),
    .op       (sample.op),
    .angle    (sample.angle),
    .dn_valid (fold_valid),
    .dn_ready (fold_ready),
    .fold     (fold)
  );

  tli_index #(
    .ROM_DEPTH (ROM_DEPTH)
  ) u_index (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fold_valid),
    .up_ready (fold_ready),
    .fold     (fold),
    .dn_valid (pt_valid),
    .dn_ready (pt_ready),
    .idx      (pt_idx),
    .frac     (pt_frac),
    .ctl      (pt_ctl)
  );

  // The last stage of the interpolator is the output register of the block.
  tli_interp #(
    .ROM_DEPTH (ROM_DEPTH)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pt_valid),
    .up_ready (pt_ready),
    .idx      (pt_idx),
    .frac     (pt_frac),
    .ctl      (pt_ctl),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .value    (result.value)
  );

endmodule
